/* sv/dsws_pkg.sv */
// Package for the display scanline word sequencer.
// Holds operation and task codes, field widths, defaults and the structs
// shared by the FIFO controller and the top level. No dependencies.
package dsws_pkg;

    localparam int FIFO_DEPTH_DEF    = 16;
    localparam int LINE_WORDS_DEF    = 64;
    localparam int VISIBLE_LIMIT_DEF = 860;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 7;
    localparam int SCAN_W  = 12;
    localparam int LINE_W  = 10;
    localparam int LAST_W  = 6;
    localparam int TASK_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_CTRL   = 3'd1;
    localparam logic [OP_W-1:0] OP_BORDER = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SYNC   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [TASK_W-1:0] TASK_NONE  = 2'd0;
    localparam logic [TASK_W-1:0] TASK_WAKE  = 2'd1;
    localparam logic [TASK_W-1:0] TASK_SLEEP = 2'd2;

    localparam logic [SCAN_W-1:0] EVEN_OFFSET = 12'd36;
    localparam logic [SCAN_W-1:0] ODD_OFFSET  = 12'd37;
    localparam logic [SCAN_W-1:0] SCAN_SAT_AT = 12'd4092;
    localparam logic [SCAN_W-1:0] SCAN_MAX    = 12'd4094;
    localparam logic [SCAN_W-1:0] SCAN_STEP   = 12'd2;

    // control word bit positions
    localparam int CB_ON      = 0;
    localparam int CB_BLANK   = 1;
    localparam int CB_PICTURE = 2;
    localparam int CB_INVERT  = 3;
    localparam int CB_ODD     = 4;
    localparam int CB_VSYNC   = 5;
    localparam int CB_KEEP    = 6;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               flush;
        logic [VALUE_W-1:0] data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic               nonempty;
        logic               full;
        logic [VALUE_W-1:0] head_data;
    } fifo_stat_t;

    typedef struct packed {
        logic [15:0]       word_value;
        logic              fetch_valid;
        logic [15:0]       fetch_address;
        logic [SLOT_W-1:0] word_slot;
        logic [SCAN_W-1:0] draw_line;
        logic              draw_valid;
        logic              invert_video;
        logic              line_done;
        logic [TASK_W-1:0] task_request;
        logic              frame_render;
        logic              clear_screen;
        logic              fifo_overflow;
    } result_t;

endpackage

/* sv/dsws_channels.sv */
// Valid/ready channel interfaces for the sequencer: requests in, results out.
// Uses widths from dsws_pkg.
interface dsws_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsws_pkg::OP_W-1:0]     op;
    logic [dsws_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dsws_out_if;
    logic                          valid;
    logic                          ready;
    logic [15:0]                   word_value;
    logic                          fetch_valid;
    logic [15:0]                   fetch_address;
    logic [dsws_pkg::SLOT_W-1:0]   word_slot;
    logic [dsws_pkg::SCAN_W-1:0]   draw_line;
    logic                          draw_valid;
    logic                          invert_video;
    logic                          line_done;
    logic [dsws_pkg::TASK_W-1:0]   task_request;
    logic                          frame_render;
    logic                          clear_screen;
    logic                          fifo_overflow;

    modport source (output valid, output word_value, output fetch_valid,
                    output fetch_address, output word_slot, output draw_line,
                    output draw_valid, output invert_video, output line_done,
                    output task_request, output frame_render,
                    output clear_screen, output fifo_overflow, input ready);
    modport sink   (input valid, input word_value, input fetch_valid,
                    input fetch_address, input word_slot, input draw_line,
                    input draw_valid, input invert_video, input line_done,
                    input task_request, input frame_render,
                    input clear_screen, input fifo_overflow, output ready);
endinterface

/* sv/dsws_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dsws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/dsws_fifo.sv */
// Line-command FIFO: pointers and fill count around a dsws_ram instance.
// The head entry is always presented, with bypass of a same-cycle write.
// Depends on dsws_pkg and dsws_ram.
module dsws_fifo #(
    parameter int DEPTH = dsws_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsws_pkg::fifo_ctrl_t ctrl,
    output dsws_pkg::fifo_stat_t stat
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          byp_reg;
    logic [dsws_pkg::VALUE_W-1:0] byp_data_reg;
    logic [dsws_pkg::VALUE_W-1:0] rd_data;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] waddr;
    logic          full;
    logic          we;

    assign full = (count_reg == CW'(DEPTH));
    assign we   = ctrl.push && !full && !ctrl.flush;

    always_comb
    begin
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (tail_sum >= (CW+1)'(DEPTH))
        begin
            waddr = IW'(tail_sum - (CW+1)'(DEPTH));
        end
        else
        begin
            waddr = IW'(tail_sum);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.flush)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (we)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            byp_reg   <= we && (waddr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ctrl.data;
    end

    // read port follows the next head so its entry is ready once that head is registered
    dsws_ram #(
        .WIDTH (dsws_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (ctrl.data),
        .raddr (head_next),
        .rdata (rd_data)
    );

    assign stat.nonempty  = (count_reg != '0);
    assign stat.full      = full;
    assign stat.head_data = byp_reg ? byp_data_reg : rd_data;

endmodule

/* sv/display_scanline_word_sequencer_top.sv */
// Display scanline word sequencer, top level.
// Requests arrive on in_ch (op, value): FIFO push, control write, border
// write, word slot tick, sync check and clear request. Every accepted
// request yields exactly one result on out_ch, in request order.
// Each result is registered in the output stage before out_ch shows it.
// Throughput: one request per cycle while in_ch.ready is high, set by
// the read-modify-write of the scanline state and the line-command RAM,
// whose head entry is pre-read every cycle, bypassing a same-cycle push.
// A scanline is LINE_WORDS+4 slot ticks. The first latches the line modes
// and may pop a line command; display-window ticks fetch line*64+word.
// Stall: a two-entry output stage (result register plus skid register)
// lets one more request in while a result waits; in_ch.ready drops only
// when both entries are full.
// Reset (rst_n, asynchronous, low): FIFO empty, all flags and counters
// cleared, no result pending. FIFO entries hold no reset value; only
// pushed entries are ever popped. No clearing pass is needed.
// Depends on dsws_pkg, dsws_channels and dsws_fifo.
module display_scanline_word_sequencer_top #(
    parameter int FIFO_DEPTH    = dsws_pkg::FIFO_DEPTH_DEF,
    parameter int LINE_WORDS    = dsws_pkg::LINE_WORDS_DEF,
    parameter int VISIBLE_LIMIT = dsws_pkg::VISIBLE_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dsws_in_if.sink    in_ch,
    dsws_out_if.source out_ch
);

    localparam int SW = dsws_pkg::SLOT_W;
    localparam int NW = dsws_pkg::SCAN_W;
    localparam logic [SW-1:0] LAST_SLOT  = SW'(LINE_WORDS + 3);
    localparam logic [SW-1:0] DISP_END   = SW'(LINE_WORDS + 2);
    localparam logic [SW-1:0] FINAL_WORD = SW'(LINE_WORDS - 1);
    localparam logic [SW-1:0] DISP_START = SW'(2);
    localparam logic [NW-1:0] VIS_LIMIT  = NW'(VISIBLE_LIMIT);

    // control flags
    logic ctrl_on_reg, ctrl_on_next;
    logic ctrl_blank_reg, ctrl_blank_next;
    logic ctrl_pic_reg, ctrl_pic_next;
    logic ctrl_inv_reg, ctrl_inv_next;
    logic ctrl_odd_reg, ctrl_odd_next;
    logic sync_seen_reg, sync_seen_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [15:0]   border_reg, border_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [dsws_pkg::LINE_W-1:0] line_num_reg, line_num_next;
    logic [dsws_pkg::LAST_W-1:0] end_word_reg, end_word_next;
    // per-line latch
    logic [15:0] ll_pat_reg, ll_pat_next;
    logic ll_blank_reg, ll_blank_next;
    logic ll_pic_reg, ll_pic_next;
    logic ll_inv_reg, ll_inv_next;
    logic ll_cmd_reg, ll_cmd_next;

    // output stage
    logic                 out_valid_reg, skid_valid_reg;
    dsws_pkg::result_t    out_data_reg, skid_data_reg;
    dsws_pkg::result_t    res;

    dsws_pkg::fifo_ctrl_t fifo_ctrl;
    dsws_pkg::fifo_stat_t fifo_stat;

    logic          accept;
    logic          out_fire;
    logic [NW-1:0] offset;
    logic [NW:0]   eff;
    logic [7:0]    pat_byte;
    logic [SW-1:0] word_idx;

    assign in_ch.ready = !skid_valid_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;

    assign offset   = ctrl_odd_reg ? dsws_pkg::ODD_OFFSET : dsws_pkg::EVEN_OFFSET;
    assign eff      = {1'b0, scan_reg} - {1'b0, offset};
    assign pat_byte = eff[1] ? border_reg[15:8] : border_reg[7:0];
    assign word_idx = slot_reg - DISP_START;

    always_comb
    begin
        ctrl_on_next    = ctrl_on_reg;
        ctrl_blank_next = ctrl_blank_reg;
        ctrl_pic_next   = ctrl_pic_reg;
        ctrl_inv_next   = ctrl_inv_reg;
        ctrl_odd_next   = ctrl_odd_reg;
        sync_seen_next  = sync_seen_reg;
        scan_next       = scan_reg;
        border_next     = border_reg;
        slot_next       = slot_reg;
        line_num_next   = line_num_reg;
        end_word_next   = end_word_reg;
        ll_pat_next     = ll_pat_reg;
        ll_blank_next   = ll_blank_reg;
        ll_pic_next     = ll_pic_reg;
        ll_inv_next     = ll_inv_reg;
        ll_cmd_next     = ll_cmd_reg;
        res             = '0;
        fifo_ctrl       = '0;
        fifo_ctrl.data  = in_ch.value;

        if (accept)
        begin
            unique case (in_ch.op)
                dsws_pkg::OP_PUSH:
                begin
                    if (fifo_stat.full)
                    begin
                        res.fifo_overflow = 1'b1;
                    end
                    else
                    begin
                        fifo_ctrl.push = 1'b1;
                    end
                end
                dsws_pkg::OP_CTRL:
                begin
                    ctrl_on_next    = in_ch.value[dsws_pkg::CB_ON];
                    ctrl_blank_next = in_ch.value[dsws_pkg::CB_BLANK];
                    ctrl_pic_next   = in_ch.value[dsws_pkg::CB_PICTURE];
                    ctrl_inv_next   = in_ch.value[dsws_pkg::CB_INVERT];
                    if (in_ch.value[dsws_pkg::CB_VSYNC])
                    begin
                        scan_next        = '0;
                        ctrl_odd_next    = in_ch.value[dsws_pkg::CB_ODD];
                        sync_seen_next   = 1'b1;
                        res.frame_render = 1'b1;
                    end
                    fifo_ctrl.flush = !in_ch.value[dsws_pkg::CB_KEEP];
                    if (!in_ch.value[dsws_pkg::CB_ON])
                    begin
                        res.task_request = dsws_pkg::TASK_SLEEP;
                    end
                end
                dsws_pkg::OP_BORDER:
                begin
                    border_next = in_ch.value;
                end
                dsws_pkg::OP_TICK:
                begin
                    // slot zero with the display off: all-zero result, no change
                    if (slot_reg != '0 || ctrl_on_reg)
                    begin
                        if (slot_reg == '0)
                        begin
                            ll_pat_next   = {pat_byte, pat_byte};
                            ll_blank_next = ctrl_blank_reg;
                            ll_pic_next   = ctrl_pic_reg;
                            ll_inv_next   = ctrl_inv_reg;
                            ll_cmd_next   = ctrl_pic_reg && !ctrl_blank_reg
                                            && fifo_stat.nonempty;
                            if (ll_cmd_next)
                            begin
                                fifo_ctrl.pop  = 1'b1;
                                line_num_next  = fifo_stat.head_data[9:0];
                                end_word_next  = fifo_stat.head_data[15:10];
                            end
                        end

                        if (ll_blank_next)
                        begin
                            res.word_value = '0;
                        end
                        else if (!ll_pic_next || slot_reg < DISP_START
                                 || slot_reg >= DISP_END)
                        begin
                            res.word_value = ll_pat_next;
                        end
                        else if (ll_cmd_next)
                        begin
                            res.fetch_valid   = 1'b1;
                            res.fetch_address = {line_num_reg, 6'b0}
                                                | {10'b0, word_idx[5:0]};
                            // switch to the next command after this one's last word
                            if (word_idx != FINAL_WORD
                                && word_idx == {1'b0, end_word_reg}
                                && fifo_stat.nonempty)
                            begin
                                fifo_ctrl.pop  = 1'b1;
                                line_num_next  = fifo_stat.head_data[9:0];
                                end_word_next  = fifo_stat.head_data[15:10];
                            end
                        end

                        res.word_slot    = slot_reg;
                        res.draw_line    = eff[NW-1:0];
                        res.draw_valid   = !eff[NW] && (eff[NW-1:0] != '0)
                                           && (eff[NW-1:0] < VIS_LIMIT);
                        res.invert_video = ll_inv_next;

                        if (slot_reg == LAST_SLOT)
                        begin
                            slot_next     = '0;
                            res.line_done = 1'b1;
                            scan_next     = (scan_reg >= dsws_pkg::SCAN_SAT_AT)
                                            ? dsws_pkg::SCAN_MAX
                                            : scan_reg + dsws_pkg::SCAN_STEP;
                            res.task_request = ctrl_on_reg ? dsws_pkg::TASK_WAKE
                                                           : dsws_pkg::TASK_NONE;
                        end
                        else
                        begin
                            slot_next = slot_reg + SW'(1);
                        end
                    end
                end
                dsws_pkg::OP_SYNC:
                begin
                    res.clear_screen = !sync_seen_reg;
                    sync_seen_next   = 1'b0;
                end
                dsws_pkg::OP_CLEAR:
                begin
                    res.task_request = dsws_pkg::TASK_SLEEP;
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_on_reg    <= 1'b0;
            ctrl_blank_reg <= 1'b0;
            ctrl_pic_reg   <= 1'b0;
            ctrl_inv_reg   <= 1'b0;
            ctrl_odd_reg   <= 1'b0;
            sync_seen_reg  <= 1'b0;
            scan_reg       <= '0;
            border_reg     <= '0;
            slot_reg       <= '0;
            line_num_reg   <= '0;
            end_word_reg   <= '0;
            ll_pat_reg     <= '0;
            ll_blank_reg   <= 1'b0;
            ll_pic_reg     <= 1'b0;
            ll_inv_reg     <= 1'b0;
            ll_cmd_reg     <= 1'b0;
        end
        else
        begin
            ctrl_on_reg    <= ctrl_on_next;
            ctrl_blank_reg <= ctrl_blank_next;
            ctrl_pic_reg   <= ctrl_pic_next;
            ctrl_inv_reg   <= ctrl_inv_next;
            ctrl_odd_reg   <= ctrl_odd_next;
            sync_seen_reg  <= sync_seen_next;
            scan_reg       <= scan_next;
            border_reg     <= border_next;
            slot_reg       <= slot_next;
            line_num_reg   <= line_num_next;
            end_word_reg   <= end_word_next;
            ll_pat_reg     <= ll_pat_next;
            ll_blank_reg   <= ll_blank_next;
            ll_pic_reg     <= ll_pic_next;
            ll_inv_reg     <= ll_inv_next;
            ll_cmd_reg     <= ll_cmd_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= res;
        end
    end

    dsws_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.word_value    = out_data_reg.word_value;
    assign out_ch.fetch_valid   = out_data_reg.fetch_valid;
    assign out_ch.fetch_address = out_data_reg.fetch_address;
    assign out_ch.word_slot     = out_data_reg.word_slot;
    assign out_ch.draw_line     = out_data_reg.draw_line;
    assign out_ch.draw_valid    = out_data_reg.draw_valid;
    assign out_ch.invert_video  = out_data_reg.invert_video;
    assign out_ch.line_done     = out_data_reg.line_done;
    assign out_ch.task_request  = out_data_reg.task_request;
    assign out_ch.frame_render  = out_data_reg.frame_render;
    assign out_ch.clear_screen  = out_data_reg.clear_screen;
    assign out_ch.fifo_overflow = out_data_reg.fifo_overflow;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for display_scanline_word_sequencer_top.
// A clocked driver and monitor compare every result with an in-bench predictor.
// Depends on dsws_pkg, dsws_channels and the sequencer RTL.
module tb_top;

    localparam int SLOTS_PER_LINE = dsws_pkg::LINE_WORDS_DEF + 4;
    localparam int LAST_LINE_WORD = dsws_pkg::LINE_WORDS_DEF - 1;
    localparam int FRAME_ITEMS    = 1050;
    localparam int MAX_REPORTS    = 100;

    // op codes the block ignores
    localparam logic [dsws_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [dsws_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [dsws_pkg::OP_W-1:0]    op;
        logic [dsws_pkg::VALUE_W-1:0] value;
    } request_t;

    logic clk;
    logic rst_n;

    dsws_in_if  in_ch();
    dsws_out_if out_ch();

    display_scanline_word_sequencer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    request_t          pending_reqs[$];
    dsws_pkg::result_t expected_words[$];
    int                mismatches;
    int                send_gap;
    int                send_calm;
    int                drain_hold;
    int                drain_calm;
    int                drain_pick;

    // sequencer state as seen from outside
    logic [dsws_pkg::VALUE_W-1:0] cmd_store [dsws_pkg::FIFO_DEPTH_DEF];
    int                           cmd_count;
    logic [3:0]                   cmd_head;
    logic [4:0]                   ctl;
    logic                         vsync_seen;
    logic [dsws_pkg::SCAN_W-1:0]  scanline;
    logic [15:0]                  border;
    logic [dsws_pkg::SLOT_W-1:0]  slot_pos;
    logic [dsws_pkg::LINE_W-1:0]  line_no;
    logic [dsws_pkg::LAST_W-1:0]  end_word;
    logic [15:0]                  lat_pattern;
    logic                         lat_blank;
    logic                         lat_picture;
    logic                         lat_invert;
    logic                         lat_cmd;

    function automatic void reset_sequencer_state();
        cmd_count   = 0;
        cmd_head    = '0;
        ctl         = '0;
        vsync_seen  = 1'b0;
        scanline    = '0;
        border      = '0;
        slot_pos    = '0;
        line_no     = '0;
        end_word    = '0;
        lat_pattern = '0;
        lat_blank   = 1'b0;
        lat_picture = 1'b0;
        lat_invert  = 1'b0;
        lat_cmd     = 1'b0;
    endfunction

    function automatic void next_line_command();
        logic [15:0] c;
        c         = cmd_store[cmd_head];
        cmd_head  = cmd_head + 4'd1;
        cmd_count = cmd_count - 1;
        line_no   = c[dsws_pkg::LINE_W-1:0];
        end_word  = c[15:dsws_pkg::LINE_W];
    endfunction

    function automatic dsws_pkg::result_t predict_word(logic [dsws_pkg::OP_W-1:0] op,
                                                       logic [dsws_pkg::VALUE_W-1:0] value);
        dsws_pkg::result_t           r;
        logic [dsws_pkg::SCAN_W-1:0] eff;
        logic [7:0]                  pb;
        logic [5:0]                  w;
        logic                        odd;
        r = '0;
        case (op)
            dsws_pkg::OP_PUSH:
            begin
                if (cmd_count < dsws_pkg::FIFO_DEPTH_DEF)
                begin
                    cmd_store[4'(cmd_head + cmd_count)] = value;
                    cmd_count = cmd_count + 1;
                end
                else
                    r.fifo_overflow = 1'b1;
            end
            dsws_pkg::OP_CTRL:
            begin
                odd = ctl[dsws_pkg::CB_ODD];
                if (value[dsws_pkg::CB_VSYNC])
                begin
                    scanline       = '0;
                    odd            = value[dsws_pkg::CB_ODD];
                    vsync_seen     = 1'b1;
                    r.frame_render = 1'b1;
                end
                ctl = {odd, value[3:0]};
                if (!value[dsws_pkg::CB_KEEP])
                begin
                    cmd_count = 0;
                    cmd_head  = '0;
                end
                if (!ctl[dsws_pkg::CB_ON])
                    r.task_request = dsws_pkg::TASK_SLEEP;
            end
            dsws_pkg::OP_BORDER:
                border = value;
            dsws_pkg::OP_TICK:
            begin
                eff = scanline - (ctl[dsws_pkg::CB_ODD] ? dsws_pkg::ODD_OFFSET
                                                        : dsws_pkg::EVEN_OFFSET);
                if (slot_pos == '0)
                begin
                    // display off: the line never starts
                    if (!ctl[dsws_pkg::CB_ON])
                        return r;
                    pb          = eff[1] ? border[15:8] : border[7:0];
                    lat_pattern = {pb, pb};
                    lat_blank   = ctl[dsws_pkg::CB_BLANK];
                    lat_picture = ctl[dsws_pkg::CB_PICTURE];
                    lat_invert  = ctl[dsws_pkg::CB_INVERT];
                    lat_cmd     = 1'b0;
                    if (lat_picture && !lat_blank && cmd_count > 0)
                    begin
                        next_line_command();
                        lat_cmd = 1'b1;
                    end
                end
                if (lat_blank)
                    r.word_value = '0;
                else if (!lat_picture || slot_pos < 2
                         || slot_pos >= dsws_pkg::LINE_WORDS_DEF + 2)
                    r.word_value = lat_pattern;
                else if (lat_cmd)
                begin
                    w               = 6'(slot_pos - 7'd2);
                    r.fetch_valid   = 1'b1;
                    r.fetch_address = {line_no, w};
                    // switch line after the command's last word
                    if (w != LAST_LINE_WORD && w == end_word && cmd_count > 0)
                        next_line_command();
                end
                r.word_slot    = slot_pos;
                r.draw_line    = eff;
                r.draw_valid   = (eff != '0) && (eff < dsws_pkg::VISIBLE_LIMIT_DEF);
                r.invert_video = lat_invert;
                if (slot_pos + 1 >= SLOTS_PER_LINE)
                begin
                    slot_pos       = '0;
                    r.line_done    = 1'b1;
                    scanline       = (scanline >= dsws_pkg::SCAN_SAT_AT)
                                     ? dsws_pkg::SCAN_MAX
                                     : scanline + dsws_pkg::SCAN_STEP;
                    r.task_request = ctl[dsws_pkg::CB_ON] ? dsws_pkg::TASK_WAKE
                                                          : dsws_pkg::TASK_NONE;
                end
                else
                    slot_pos = slot_pos + 7'd1;
            end
            dsws_pkg::OP_SYNC:
            begin
                r.clear_screen = !vsync_seen;
                vsync_seen     = 1'b0;
            end
            dsws_pkg::OP_CLEAR:
                r.task_request = dsws_pkg::TASK_SLEEP;
            default:
                ;
        endcase
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            calm = $urandom_range(30, 200);
            return 0;
        end
        if (r < 120)
            return 0;
        if (r < 180)
            return $urandom_range(1, 2);
        if (r < 196)
            return $urandom_range(3, 8);
        return $urandom_range(9, 24);
    endfunction

    function automatic void queue_request(logic [dsws_pkg::OP_W-1:0] op,
                                          logic [dsws_pkg::VALUE_W-1:0] value);
        request_t q;
        q.op    = op;
        q.value = value;
        pending_reqs.push_back(q);
    endfunction

    function automatic logic [15:0] ctrl_word(logic vsync);
        logic [15:0] v;
        v                       = 16'($urandom);
        v[dsws_pkg::CB_VSYNC]   = vsync;
        v[dsws_pkg::CB_KEEP]    = ($urandom_range(0, 9) != 0);
        v[dsws_pkg::CB_ON]      = ($urandom_range(0, 7) != 0);
        v[dsws_pkg::CB_PICTURE] = ($urandom_range(0, 3) != 0);
        v[dsws_pkg::CB_BLANK]   = ($urandom_range(0, 5) == 0);
        return v;
    endfunction

    function automatic logic [15:0] command_word();
        logic [dsws_pkg::LAST_W-1:0] lw;
        case ($urandom_range(0, 3))
            0:       lw = '0;
            1:       lw = dsws_pkg::LAST_W'(LAST_LINE_WORD);
            2:       lw = dsws_pkg::LAST_W'($urandom_range(0, 8));
            default: lw = dsws_pkg::LAST_W'($urandom);
        endcase
        return {lw, dsws_pkg::LINE_W'($urandom)};
    endfunction

    // slot ticks with side requests mixed in at random
    function automatic void queue_ticks(int count, int extra_pct);
        int r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < extra_pct)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    queue_request(dsws_pkg::OP_PUSH, command_word());
                else if (r < 55)
                    queue_request(dsws_pkg::OP_SYNC, 16'($urandom));
                else if (r < 65)
                    queue_request(dsws_pkg::OP_BORDER, 16'($urandom));
                else if (r < 75)
                    queue_request(dsws_pkg::OP_CLEAR, 16'($urandom));
                else if (r < 85)
                    queue_request($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                                  16'($urandom));
                else
                    queue_request(dsws_pkg::OP_CTRL, ctrl_word(1'b0));
            end
            queue_request(dsws_pkg::OP_TICK, 16'($urandom));
        end
    endfunction

    function automatic void queue_frame();
        queue_request(dsws_pkg::OP_CTRL, ctrl_word(1'b1));
        queue_request(dsws_pkg::OP_BORDER, 16'($urandom));
        repeat ($urandom_range(0, 6))
            queue_request(dsws_pkg::OP_PUSH, command_word());
        if ($urandom_range(0, 5) == 0)
            repeat (18) queue_request(dsws_pkg::OP_PUSH, command_word());
        queue_ticks($urandom_range(1, 2) * SLOTS_PER_LINE, 6);
        // broken line: stop part way through
        if ($urandom_range(0, 4) == 0)
            queue_ticks($urandom_range(1, 90), 10);
        if ($urandom_range(0, 1) != 0)
            queue_request(dsws_pkg::OP_SYNC, 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            queue_request(dsws_pkg::OP_SYNC, 16'($urandom));
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t %s: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // request driver: holds a request until taken, then predicts its result
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.op    <= '0;
            in_ch.value <= '0;
            send_gap    = 0;
            send_calm   = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
            begin
                expected_words.push_back(predict_word(in_ch.op, in_ch.value));
                send_gap = pick_gap(send_calm);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nxt = pending_reqs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.op    <= nxt.op;
                in_ch.value <= nxt.value;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            drain_hold   = 0;
            drain_calm   = 0;
        end
        else if (drain_hold > 0)
        begin
            drain_hold--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            drain_pick = pick_gap(drain_calm);
            if (drain_pick > 0)
                drain_hold = drain_pick - 1;
            out_ch.ready <= (drain_pick == 0);
        end
    end

    always @(posedge clk)
    begin : check_results
        dsws_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t unexpected result: expected none, actual slot %0d word %0h",
                             $time, out_ch.word_slot, out_ch.word_value);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("word_value", want.word_value, out_ch.word_value);
                check_field("fetch_valid", 16'(want.fetch_valid),
                            16'(out_ch.fetch_valid));
                check_field("fetch_address", want.fetch_address, out_ch.fetch_address);
                check_field("word_slot", 16'(want.word_slot), 16'(out_ch.word_slot));
                check_field("draw_line", 16'(want.draw_line), 16'(out_ch.draw_line));
                check_field("draw_valid", 16'(want.draw_valid), 16'(out_ch.draw_valid));
                check_field("invert_video", 16'(want.invert_video),
                            16'(out_ch.invert_video));
                check_field("line_done", 16'(want.line_done), 16'(out_ch.line_done));
                check_field("task_request", 16'(want.task_request),
                            16'(out_ch.task_request));
                check_field("frame_render", 16'(want.frame_render),
                            16'(out_ch.frame_render));
                check_field("clear_screen", 16'(want.clear_screen),
                            16'(out_ch.clear_screen));
                check_field("fifo_overflow", 16'(want.fifo_overflow),
                            16'(out_ch.fifo_overflow));
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        mismatches = 0;
        reset_sequencer_state();

        // directed: ignored codes, sync check with no vsync, tick while off, clear, control, border and push writes
        queue_request(OP_SPARE_A, 16'hffff);
        queue_request(OP_SPARE_B, 16'h0000);
        queue_request(dsws_pkg::OP_SYNC, 16'h0000);
        queue_request(dsws_pkg::OP_TICK, 16'hffff);
        queue_request(dsws_pkg::OP_CLEAR, 16'h0000);
        queue_request(dsws_pkg::OP_CTRL, 16'h0000);
        queue_request(dsws_pkg::OP_BORDER, 16'hffff);
        queue_request(dsws_pkg::OP_BORDER, 16'h0000);
        queue_request(dsws_pkg::OP_BORDER, 16'h12ef);
        queue_request(dsws_pkg::OP_PUSH, 16'hffff);
        queue_request(dsws_pkg::OP_PUSH, 16'h0000);
        // vsync, odd field, keep FIFO, every mode bit
        queue_request(dsws_pkg::OP_CTRL, 16'h007f);
        queue_request(dsws_pkg::OP_SYNC, 16'hffff);
        queue_request(dsws_pkg::OP_SYNC, 16'h0000);
        // display and picture on, no vsync: odd field stays
        queue_request(dsws_pkg::OP_CTRL, 16'hffc5);
        queue_request(dsws_pkg::OP_TICK, 16'h0000);
        queue_request(dsws_pkg::OP_TICK, 16'h0000);
        queue_request(dsws_pkg::OP_TICK, 16'h0000);
        queue_request(dsws_pkg::OP_TICK, 16'h0000);

        while (pending_reqs.size() < FRAME_ITEMS)
            queue_frame();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() > 0 || in_ch.valid)
            @(posedge clk);
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
